[design/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and codes for the voxel face culling core: item kinds, face
// numbering, default chunk size and the per-face control word.
// ----------------------------------------------------------------------------
package vfc_pkg;

	localparam int unsigned CHUNK_WIDTH_DEF = 16;
	localparam int unsigned CHUNK_TALL_DEF  = 32;

	localparam int unsigned COORD_XZ_W = 4;
	localparam int unsigned COORD_Y_W  = 5;
	localparam int unsigned BLOCK_W    = 8;
	localparam int unsigned NBR_W      = 4;
	localparam int unsigned VERTEX_W   = 18;
	localparam int unsigned FACES      = 6;
	localparam int unsigned FACE_IDX_W = 3;
	localparam int unsigned COUNT_W    = 3;

	typedef enum logic [1:0] {
		KIND_WRITE_VOXEL  = 2'd0,
		KIND_WRITE_BORDER = 2'd1,
		KIND_RESTART      = 2'd2,
		KIND_QUERY        = 2'd3
	} kind_t;

	localparam logic [FACE_IDX_W-1:0] FACE_ZN  = 3'd0;
	localparam logic [FACE_IDX_W-1:0] FACE_ZP  = 3'd1;
	localparam logic [FACE_IDX_W-1:0] FACE_XN  = 3'd2;
	localparam logic [FACE_IDX_W-1:0] FACE_XP  = 3'd3;
	localparam logic [FACE_IDX_W-1:0] FACE_TOP = 3'd4;
	localparam logic [FACE_IDX_W-1:0] FACE_BOT = 3'd5;

	localparam logic [1:0] SIDE_ZN = 2'd0;
	localparam logic [1:0] SIDE_ZP = 2'd1;
	localparam logic [1:0] SIDE_XN = 2'd2;
	localparam logic [1:0] SIDE_XP = 2'd3;

	// per-face lookup info from the address unit
	typedef struct packed {
		logic at_edge;      // neighbor lies outside the chunk
		logic nbr_present;  // edge face backed by a present neighbor chunk
	} face_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_FACE = 3'b010,
		S_LAST = 3'b100
	} state_t;

endpackage

[design/vfc_ram.sv]
// ----------------------------------------------------------------------------
// vfc_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vfc_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 8192,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/vfc_nbr_addr.sv]
// ----------------------------------------------------------------------------
// vfc_nbr_addr
// Neighbor address unit: one shared add/subtract steps from the center voxel
// address to the neighbor of the selected face, plus border cell address.
// ----------------------------------------------------------------------------
module vfc_nbr_addr
	import vfc_pkg::*;
#(
	parameter int unsigned CHUNK_WIDTH = CHUNK_WIDTH_DEF,
	parameter int unsigned CHUNK_TALL  = CHUNK_TALL_DEF,
	parameter int unsigned VA_W        = $clog2(CHUNK_WIDTH * CHUNK_TALL * CHUNK_WIDTH),
	parameter int unsigned BA_W        = $clog2(4 * CHUNK_WIDTH * CHUNK_TALL)
) (
	input  logic [FACE_IDX_W-1:0] face,
	input  logic [VA_W-1:0]       center,
	input  logic [COORD_XZ_W-1:0] x,
	input  logic [COORD_Y_W-1:0]  y,
	input  logic [COORD_XZ_W-1:0] z,
	input  logic [NBR_W-1:0]      present,
	output logic [VA_W-1:0]       vaddr,
	output logic [BA_W-1:0]       baddr,
	output face_ctl_t             ctl
);

	localparam int unsigned SLICE = CHUNK_TALL * CHUNK_WIDTH;
	localparam int unsigned PLANE = CHUNK_WIDTH * CHUNK_TALL;

	logic [VA_W-1:0]       delta;
	logic                  sub;
	logic                  edge_hit;
	logic                  side_face;
	logic [1:0]            side;
	logic [COORD_XZ_W-1:0] col;

	always_comb begin
		delta     = VA_W'(1);
		sub       = 1'b0;
		edge_hit  = 1'b0;
		side_face = 1'b0;
		side      = SIDE_ZN;
		col       = x;
		case (face)
			FACE_ZN: begin
				sub       = 1'b1;
				edge_hit  = (z == '0);
				side_face = 1'b1;
				side      = SIDE_ZN;
			end
			FACE_ZP: begin
				edge_hit  = (int'(z) == CHUNK_WIDTH - 1);
				side_face = 1'b1;
				side      = SIDE_ZP;
			end
			FACE_XN: begin
				delta     = VA_W'(SLICE);
				sub       = 1'b1;
				edge_hit  = (x == '0);
				side_face = 1'b1;
				side      = SIDE_XN;
				col       = z;
			end
			FACE_XP: begin
				delta     = VA_W'(SLICE);
				edge_hit  = (int'(x) == CHUNK_WIDTH - 1);
				side_face = 1'b1;
				side      = SIDE_XP;
				col       = z;
			end
			FACE_TOP: begin
				delta    = VA_W'(CHUNK_WIDTH);
				edge_hit = (int'(y) == CHUNK_TALL - 1);
			end
			FACE_BOT: begin
				delta    = VA_W'(CHUNK_WIDTH);
				sub      = 1'b1;
				edge_hit = (y == '0);
			end
			default: begin
				edge_hit = 1'b1;
			end
		endcase
	end

	// the shared adder; at an edge the center address is reused to stay in range
	always_comb begin
		if (edge_hit) begin
			vaddr = center;
		end else if (sub) begin
			vaddr = center - delta;
		end else begin
			vaddr = center + delta;
		end
	end

	assign baddr = BA_W'(int'(side) * PLANE + int'(col) * CHUNK_TALL + int'(y));

	assign ctl.at_edge     = edge_hit;
	assign ctl.nbr_present = edge_hit & side_face & present[side];

endmodule

[design/voxel_face_culling_core.sv]
// ----------------------------------------------------------------------------
// voxel_face_culling_core
// Hidden-face culling for one voxel chunk with four neighbor border planes.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low, with kind, coordinates, border_side
//   and block_value. Voxel writes, border writes and mesh restarts finish at
//   the accepting edge; busy stays low and the next item can follow at once.
//   A query reads the center voxel, then one neighbor per cycle through a
//   single read port of the voxel memory (border plane read alongside), so a
//   query of a non-empty voxel keeps busy high while it walks the faces. The
//   result_valid beat fills the first cycle with busy low; the next item can
//   be taken at the edge that ends that beat. A query of an empty voxel drops
//   busy after the center read and gives no beat; an out of range query
//   finishes at the accepting edge and gives no beat.
//   Results are strobed by result_valid for exactly one cycle; the receiver
//   cannot stall. neighbor_present is written through cfg_valid/cfg_data,
//   always ready, and should only change while idle.
//   Reset clears the sequencer, the vertex counter and neighbor_present; the
//   voxel and border memories hold whatever was last written.
// ----------------------------------------------------------------------------
module voxel_face_culling_core
	import vfc_pkg::*;
#(
	parameter int unsigned CHUNK_WIDTH = CHUNK_WIDTH_DEF,
	parameter int unsigned CHUNK_TALL  = CHUNK_TALL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [COORD_XZ_W-1:0] coord_x,
	input  logic [COORD_Y_W-1:0]  coord_y,
	input  logic [COORD_XZ_W-1:0] coord_z,
	input  logic [1:0]            border_side,
	input  logic [BLOCK_W-1:0]    block_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [NBR_W-1:0]      cfg_data,
	output logic                  result_valid,
	output logic [FACES-1:0]      face_mask,
	output logic [COUNT_W-1:0]    face_count,
	output logic [BLOCK_W-1:0]    voxel_block,
	output logic [VERTEX_W-1:0]   first_vertex
);

	localparam int unsigned VOX_DEPTH = CHUNK_WIDTH * CHUNK_TALL * CHUNK_WIDTH;
	localparam int unsigned BRD_DEPTH = 4 * CHUNK_WIDTH * CHUNK_TALL;
	localparam int unsigned VA_W      = $clog2(VOX_DEPTH);
	localparam int unsigned BA_W      = $clog2(BRD_DEPTH);
	localparam int unsigned SLICE     = CHUNK_TALL * CHUNK_WIDTH;
	localparam int unsigned PLANE     = CHUNK_WIDTH * CHUNK_TALL;

	state_t                state_q;
	logic [FACE_IDX_W-1:0] step_q;
	logic [COORD_XZ_W-1:0] x_q;
	logic [COORD_Y_W-1:0]  y_q;
	logic [COORD_XZ_W-1:0] z_q;
	logic [VA_W-1:0]       center_q;
	logic [BLOCK_W-1:0]    blk_q;
	logic [FACES-1:0]      mask_q;
	logic [NBR_W-1:0]      nbr_present_q;
	logic [VERTEX_W-1:0]   vcount_q;
	logic                  first_s1;
	logic [FACE_IDX_W-1:0] face_s1;
	face_ctl_t             ctl_s1;

	logic                  accept;
	logic                  vox_in_range;
	logic [VA_W-1:0]       in_addr;
	logic [COORD_XZ_W-1:0] bcol;
	logic                  brd_in_range;
	logic [BA_W-1:0]       brd_waddr;
	logic                  vox_we;
	logic                  brd_we;
	logic [VA_W-1:0]       vox_raddr;
	logic [BLOCK_W-1:0]    vox_rdata;
	logic                  brd_rdata;
	logic [VA_W-1:0]       nbr_vaddr;
	logic [BA_W-1:0]       nbr_baddr;
	face_ctl_t             nbr_ctl;
	logic                  face_open;
	logic [FACES-1:0]      final_mask;
	logic [COUNT_W-1:0]    final_count;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign vox_in_range = (int'(coord_x) < CHUNK_WIDTH) && (int'(coord_y) < CHUNK_TALL)
		&& (int'(coord_z) < CHUNK_WIDTH);
	assign in_addr = VA_W'(int'(coord_x) * SLICE + int'(coord_y) * CHUNK_WIDTH
		+ int'(coord_z));

	// z-/z+ planes are indexed by x, x-/x+ planes by z
	assign bcol = (border_side == SIDE_ZN || border_side == SIDE_ZP) ? coord_x : coord_z;
	assign brd_in_range = (int'(bcol) < CHUNK_WIDTH) && (int'(coord_y) < CHUNK_TALL);
	assign brd_waddr = BA_W'(int'(border_side) * PLANE + int'(bcol) * CHUNK_TALL
		+ int'(coord_y));

	assign vox_we = accept && (kind == KIND_WRITE_VOXEL) && vox_in_range;
	assign brd_we = accept && (kind == KIND_WRITE_BORDER) && brd_in_range;

	assign vox_raddr = (state_q == S_IDLE) ? in_addr : nbr_vaddr;

	vfc_ram #(
		.DATA_W (BLOCK_W),
		.DEPTH  (VOX_DEPTH),
		.ADDR_W (VA_W)
	) u_voxel_ram (
		.clk   (clk),
		.we    (vox_we),
		.waddr (in_addr),
		.wdata (block_value),
		.raddr (vox_raddr),
		.rdata (vox_rdata)
	);

	vfc_ram #(
		.DATA_W (1),
		.DEPTH  (BRD_DEPTH),
		.ADDR_W (BA_W)
	) u_border_ram (
		.clk   (clk),
		.we    (brd_we),
		.waddr (brd_waddr),
		.wdata (|block_value),
		.raddr (nbr_baddr),
		.rdata (brd_rdata)
	);

	vfc_nbr_addr #(
		.CHUNK_WIDTH (CHUNK_WIDTH),
		.CHUNK_TALL  (CHUNK_TALL),
		.VA_W        (VA_W),
		.BA_W        (BA_W)
	) u_nbr_addr (
		.face    (step_q),
		.center  (center_q),
		.x       (x_q),
		.y       (y_q),
		.z       (z_q),
		.present (nbr_present_q),
		.vaddr   (nbr_vaddr),
		.baddr   (nbr_baddr),
		.ctl     (nbr_ctl)
	);

	// face exposure from the beat of read data that just came back
	assign face_open = ctl_s1.at_edge ? (!ctl_s1.nbr_present || !brd_rdata)
		: (vox_rdata == '0);

	always_comb begin
		final_mask = mask_q;
		final_mask[face_s1] = face_open;
		final_count = '0;
		for (int i = 0; i < FACES; i++) begin
			final_count = final_count + COUNT_W'(final_mask[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			first_s1      <= 1'b0;
			nbr_present_q <= '0;
			vcount_q      <= '0;
			result_valid  <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				nbr_present_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_RESTART) begin
							vcount_q <= '0;
						end
						if (kind == KIND_QUERY && vox_in_range) begin
							state_q  <= S_FACE;
							step_q   <= FACE_ZN;
							first_s1 <= 1'b1;
						end
					end
				end
				S_FACE: begin
					first_s1 <= 1'b0;
					if (first_s1 && vox_rdata == '0) begin
						state_q <= S_IDLE;
					end else begin
						if (step_q == FACE_BOT) begin
							state_q <= S_LAST;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				S_LAST: begin
					state_q      <= S_IDLE;
					result_valid <= 1'b1;
					vcount_q     <= vcount_q + VERTEX_W'({final_count, 2'b00});
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= coord_x;
			y_q      <= coord_y;
			z_q      <= coord_z;
			center_q <= in_addr;
		end
		ctl_s1  <= nbr_ctl;
		face_s1 <= step_q;
		if (state_q == S_FACE) begin
			if (first_s1) begin
				blk_q  <= vox_rdata;
				mask_q <= '0;
			end else begin
				mask_q[face_s1] <= face_open;
			end
		end
		if (state_q == S_LAST) begin
			face_mask    <= final_mask;
			face_count   <= final_count;
			voxel_block  <= blk_q;
			first_vertex <= vcount_q;
		end
	end

endmodule

[bench/face_cull_checker.sv]
// ----------------------------------------------------------------------------
// face_cull_checker
// Watches the item, neighbor-register and result channels of the face culling
// core, keeps its own copy of the voxel grid, border planes and vertex base,
// predicts each query beat and compares it field by field as it comes out.
// ----------------------------------------------------------------------------
module face_cull_checker
	import vfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [1:0]            kind,
	input  logic [COORD_XZ_W-1:0] coord_x,
	input  logic [COORD_Y_W-1:0]  coord_y,
	input  logic [COORD_XZ_W-1:0] coord_z,
	input  logic [1:0]            border_side,
	input  logic [BLOCK_W-1:0]    block_value,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [NBR_W-1:0]      cfg_data,
	input  logic                  result_valid,
	input  logic [FACES-1:0]      face_mask,
	input  logic [COUNT_W-1:0]    face_count,
	input  logic [BLOCK_W-1:0]    voxel_block,
	input  logic [VERTEX_W-1:0]   first_vertex,
	output int unsigned           fail_count,
	output int unsigned           faces_due
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [COORD_XZ_W-1:0] XZ_LAST = COORD_XZ_W'(CHUNK_WIDTH_DEF - 1);
	localparam logic [COORD_Y_W-1:0]  Y_LAST  = COORD_Y_W'(CHUNK_TALL_DEF - 1);

	typedef struct packed {
		logic [FACES-1:0]    mask;
		logic [COUNT_W-1:0]  cnt;
		logic [BLOCK_W-1:0]  blk;
		logic [VERTEX_W-1:0] base;
	} face_result_t;

	// address layout matches {x, y, z} and {side, column, y}
	bit [BLOCK_W-1:0]  voxel_ids [0:(1 << (2*COORD_XZ_W + COORD_Y_W)) - 1];
	bit                border_occ [0:(1 << (2 + COORD_XZ_W + COORD_Y_W)) - 1];
	logic [NBR_W-1:0]  nbr_mask;
	logic [VERTEX_W-1:0] vertex_base;
	face_result_t      faces_expected [$];

	function automatic logic side_open(input logic [1:0] side,
			input logic [COORD_XZ_W-1:0] col, input logic [COORD_Y_W-1:0] y);
		if (!nbr_mask[side])
			return 1'b1;
		return !border_occ[{side, col, y}];
	endfunction

	function automatic face_result_t cull_faces(input logic [COORD_XZ_W-1:0] x,
			input logic [COORD_Y_W-1:0] y, input logic [COORD_XZ_W-1:0] z);
		face_result_t r;
		logic [FACES-1:0] open;
		open[FACE_ZN] = (z == 0) ? side_open(SIDE_ZN, x, y)
			: (voxel_ids[{x, y, z - 4'd1}] == 0);
		open[FACE_ZP] = (z == XZ_LAST) ? side_open(SIDE_ZP, x, y)
			: (voxel_ids[{x, y, z + 4'd1}] == 0);
		open[FACE_XN] = (x == 0) ? side_open(SIDE_XN, z, y)
			: (voxel_ids[{x - 4'd1, y, z}] == 0);
		open[FACE_XP] = (x == XZ_LAST) ? side_open(SIDE_XP, z, y)
			: (voxel_ids[{x + 4'd1, y, z}] == 0);
		open[FACE_TOP] = (y == Y_LAST) || (voxel_ids[{x, y + 5'd1, z}] == 0);
		open[FACE_BOT] = (y == 0) || (voxel_ids[{x, y - 5'd1, z}] == 0);
		r.mask = open;
		r.cnt = '0;
		for (int i = 0; i < FACES; i++)
			r.cnt = r.cnt + COUNT_W'(open[i]);
		r.blk = voxel_ids[{x, y, z}];
		r.base = vertex_base;
		return r;
	endfunction

	task automatic report_miss(input bit unexpected, input face_result_t want,
			input face_result_t got);
		fail_count++;
		if (fail_count <= 10) begin
			if (unexpected)
				$display("%0t: face beat with none expected: mask=%b count=%0d block=%0d base=%0d",
					$realtime, got.mask, got.cnt, got.blk, got.base);
			else
				$display("%0t: face beat wrong: want mask=%b count=%0d block=%0d base=%0d",
					$realtime, want.mask, want.cnt, want.blk, want.base,
					"\n            got mask=%b count=%0d block=%0d base=%0d",
					got.mask, got.cnt, got.blk, got.base);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		face_result_t want;
		face_result_t got;
		logic [COORD_XZ_W-1:0] col;
		if (!arst_n) begin
			vertex_base = '0;
			nbr_mask = '0;
			faces_expected.delete();
		end else begin
			if (result_valid) begin
				got.mask = face_mask;
				got.cnt = face_count;
				got.blk = voxel_block;
				got.base = first_vertex;
				if (faces_expected.size() == 0) begin
					report_miss(1'b1, got, got);
				end else begin
					want = faces_expected.pop_front();
					if (got.mask !== want.mask || got.cnt !== want.cnt
							|| got.blk !== want.blk || got.base !== want.base)
						report_miss(1'b0, want, got);
				end
			end
			if (cfg_valid && cfg_ready)
				nbr_mask = cfg_data;
			if (start && !busy) begin
				case (kind_t'(kind))
					KIND_WRITE_VOXEL: begin
						if (coord_x < CHUNK_WIDTH_DEF && coord_y < CHUNK_TALL_DEF
								&& coord_z < CHUNK_WIDTH_DEF)
							voxel_ids[{coord_x, coord_y, coord_z}] = block_value;
					end
					KIND_WRITE_BORDER: begin
						col = (border_side == SIDE_ZN || border_side == SIDE_ZP)
							? coord_x : coord_z;
						if (col < CHUNK_WIDTH_DEF && coord_y < CHUNK_TALL_DEF)
							border_occ[{border_side, col, coord_y}] = |block_value;
					end
					KIND_RESTART: begin
						vertex_base = '0;
					end
					default: begin
						// empty or out of range voxel: no beat and the base holds
						if (coord_x < CHUNK_WIDTH_DEF && coord_y < CHUNK_TALL_DEF
								&& coord_z < CHUNK_WIDTH_DEF
								&& voxel_ids[{coord_x, coord_y, coord_z}] != 0) begin
							want = cull_faces(coord_x, coord_y, coord_z);
							faces_expected = {faces_expected, want};
							vertex_base = vertex_base + VERTEX_W'({want.cnt, 2'b00});
						end
					end
				endcase
			end
		end
		faces_due = faces_expected.size();
	end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the voxel face culling core: directed corner and edge queries,
// then phases of random chunk edits and queries under several neighbor
// settings, then a closing run of back to back queries on one lone voxel.
// ----------------------------------------------------------------------------
module tb_top;

	import vfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS = 1150;
	localparam logic [COORD_XZ_W-1:0] XZ_LAST = COORD_XZ_W'(CHUNK_WIDTH_DEF - 1);
	localparam logic [COORD_Y_W-1:0]  Y_LAST  = COORD_Y_W'(CHUNK_TALL_DEF - 1);
	// isolated voxel, 24 vertices per query
	localparam int LONE_QUERIES = 24;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            kind = '0;
	logic [COORD_XZ_W-1:0] coord_x = '0;
	logic [COORD_Y_W-1:0]  coord_y = '0;
	logic [COORD_XZ_W-1:0] coord_z = '0;
	logic [1:0]            border_side = '0;
	logic [BLOCK_W-1:0]    block_value = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [NBR_W-1:0]      cfg_data = '0;
	logic                  result_valid;
	logic [FACES-1:0]      face_mask;
	logic [COUNT_W-1:0]    face_count;
	logic [BLOCK_W-1:0]    voxel_block;
	logic [VERTEX_W-1:0]   first_vertex;
	int unsigned           fail_count;
	int unsigned           faces_due;

	int items_sent = 0;
	int gap_pct = 25;
	bit vox_set [0:(1 << (2*COORD_XZ_W + COORD_Y_W)) - 1];
	bit bord_set [0:(1 << (2 + COORD_XZ_W + COORD_Y_W)) - 1];

	voxel_face_culling_core dut (.*);

	face_cull_checker chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [BLOCK_W-1:0] rand_block();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return '0;
		if (r == 4)
			return 8'hFF;
		return BLOCK_W'($urandom_range(1, 255));
	endfunction

	function automatic logic [BLOCK_W-1:0] rand_occ();
		if ($urandom_range(0, 1))
			return '0;
		return BLOCK_W'($urandom_range(1, 255));
	endfunction

	// clustered near the faces and the middle so neighbors get reused
	function automatic logic [COORD_XZ_W-1:0] pick_xz();
		case ($urandom_range(0, 9))
			0, 1, 2: return COORD_XZ_W'($urandom_range(0, 2));
			3, 4, 5: return COORD_XZ_W'($urandom_range(XZ_LAST - 2, XZ_LAST));
			6, 7: return COORD_XZ_W'($urandom_range(6, 9));
			default: return COORD_XZ_W'($urandom_range(0, XZ_LAST));
		endcase
	endfunction

	function automatic logic [COORD_Y_W-1:0] pick_y();
		case ($urandom_range(0, 9))
			0, 1, 2: return COORD_Y_W'($urandom_range(0, 2));
			3, 4, 5: return COORD_Y_W'($urandom_range(Y_LAST - 2, Y_LAST));
			6, 7: return COORD_Y_W'($urandom_range(14, 17));
			default: return COORD_Y_W'($urandom_range(0, Y_LAST));
		endcase
	endfunction

	// one beat on the item channel; returns at the accepting edge
	task automatic issue(input kind_t k, input logic [COORD_XZ_W-1:0] x,
			input logic [COORD_Y_W-1:0] y, input logic [COORD_XZ_W-1:0] z,
			input logic [1:0] side, input logic [BLOCK_W-1:0] val);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		border_side <= side;
		block_value <= val;
		do @(negedge clk); while (busy);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic put_voxel(input logic [COORD_XZ_W-1:0] x,
			input logic [COORD_Y_W-1:0] y, input logic [COORD_XZ_W-1:0] z,
			input logic [BLOCK_W-1:0] val);
		issue(KIND_WRITE_VOXEL, x, y, z, 2'($urandom_range(0, 3)), val);
		vox_set[{x, y, z}] = 1'b1;
	endtask

	task automatic put_border(input logic [1:0] side, input logic [COORD_XZ_W-1:0] col,
			input logic [COORD_Y_W-1:0] y, input logic [BLOCK_W-1:0] val);
		logic [COORD_XZ_W-1:0] spare;
		spare = COORD_XZ_W'($urandom_range(0, XZ_LAST));
		if (side == SIDE_ZN || side == SIDE_ZP)
			issue(KIND_WRITE_BORDER, col, y, spare, side, val);
		else
			issue(KIND_WRITE_BORDER, spare, y, col, side, val);
		bord_set[{side, col, y}] = 1'b1;
	endtask

	task automatic fill_voxel(input logic [COORD_XZ_W-1:0] x,
			input logic [COORD_Y_W-1:0] y, input logic [COORD_XZ_W-1:0] z);
		if (!vox_set[{x, y, z}])
			put_voxel(x, y, z, rand_block());
	endtask

	task automatic fill_border(input logic [1:0] side, input logic [COORD_XZ_W-1:0] col,
			input logic [COORD_Y_W-1:0] y);
		if (!bord_set[{side, col, y}])
			put_border(side, col, y, rand_occ());
	endtask

	// everything a query may read gets written first, border cells included
	task automatic query(input logic [COORD_XZ_W-1:0] x,
			input logic [COORD_Y_W-1:0] y, input logic [COORD_XZ_W-1:0] z);
		fill_voxel(x, y, z);
		if (z != 0) fill_voxel(x, y, z - 4'd1);
		else fill_border(SIDE_ZN, x, y);
		if (z != XZ_LAST) fill_voxel(x, y, z + 4'd1);
		else fill_border(SIDE_ZP, x, y);
		if (x != 0) fill_voxel(x - 4'd1, y, z);
		else fill_border(SIDE_XN, z, y);
		if (x != XZ_LAST) fill_voxel(x + 4'd1, y, z);
		else fill_border(SIDE_XP, z, y);
		if (y != Y_LAST) fill_voxel(x, y + 5'd1, z);
		if (y != 0) fill_voxel(x, y - 5'd1, z);
		issue(KIND_QUERY, x, y, z, 2'($urandom_range(0, 3)),
			BLOCK_W'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (busy || faces_due != 0);
		// extra idle margin once the core is quiet
		repeat (12) @(posedge clk);
	endtask

	task automatic set_neighbors(input logic [NBR_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int ph;
		int pick;
		int stop_at;
		logic [COORD_XZ_W-1:0] x;
		logic [COORD_Y_W-1:0] y;
		logic [COORD_XZ_W-1:0] z;
		logic [1:0] s;
		logic [NBR_W-1:0] nb;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// low corner: z- backed by an occupied border, x- by an empty one
		set_neighbors(4'hF);
		put_voxel(4'd0, 5'd0, 4'd0, 8'hFF);
		put_voxel(4'd1, 5'd0, 4'd0, 8'h00);
		put_voxel(4'd0, 5'd1, 4'd0, 8'h07);
		put_voxel(4'd0, 5'd0, 4'd1, 8'h00);
		put_border(SIDE_ZN, 4'd0, 5'd0, 8'h01);
		put_border(SIDE_XN, 4'd0, 5'd0, 8'h00);
		query(4'd0, 5'd0, 4'd0);
		// high corner, top face always open
		put_voxel(XZ_LAST, Y_LAST, XZ_LAST, 8'h01);
		put_voxel(XZ_LAST - 4'd1, Y_LAST, XZ_LAST, 8'h09);
		put_voxel(XZ_LAST, Y_LAST - 5'd1, XZ_LAST, 8'h00);
		put_voxel(XZ_LAST, Y_LAST, XZ_LAST - 4'd1, 8'hC8);
		put_border(SIDE_ZP, XZ_LAST, Y_LAST, 8'h80);
		put_border(SIDE_XP, XZ_LAST, Y_LAST, 8'h03);
		query(XZ_LAST, Y_LAST, XZ_LAST);
		issue(KIND_RESTART, XZ_LAST, Y_LAST, XZ_LAST, SIDE_XP, 8'hFF);
		query(4'd0, 5'd0, 4'd1);
		query(4'd0, 5'd0, 4'd0);
		// no neighbor chunks: every edge face open
		set_neighbors(4'h0);
		query(XZ_LAST, Y_LAST, XZ_LAST);
		put_border(SIDE_ZN, 4'd0, 5'd0, 8'h00);
		put_voxel(4'd0, 5'd0, 4'd0, 8'h00);
		query(4'd0, 5'd0, 4'd0);
		query(4'd0, 5'd1, 4'd0);

		ph = 0;
		while (items_sent < ITEMS) begin
			case (ph % 4)
				0: nb = NBR_W'($urandom_range(1, 14));
				1: nb = 4'hF;
				2: nb = 4'h0;
				default: nb = NBR_W'($urandom_range(0, 15));
			endcase
			set_neighbors(nb);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 25;
				default: gap_pct = 50;
			endcase
			stop_at = items_sent + 150 + $urandom_range(0, 100);
			while (items_sent < stop_at && items_sent < ITEMS) begin
				pick = $urandom_range(0, 99);
				x = pick_xz();
				y = pick_y();
				z = pick_xz();
				if (pick < 60) begin
					if ($urandom_range(0, 1))
						put_voxel(x, y, z, rand_block());
					query(x, y, z);
					if ($urandom_range(0, 3) == 0)
						query(x, y, z);
				end else if (pick < 75) begin
					put_voxel(x, y, z, rand_block());
				end else if (pick < 87) begin
					s = 2'($urandom_range(0, 3));
					put_border(s, (s == SIDE_ZN || s == SIDE_ZP) ? x : z, y, rand_occ());
				end else if (pick < 90) begin
					issue(KIND_RESTART, x, y, z, 2'($urandom_range(0, 3)), rand_block());
				end else begin
					// change the border behind an edge voxel, then look at it
					s = 2'($urandom_range(0, 3));
					case (s)
						SIDE_ZN: z = '0;
						SIDE_ZP: z = XZ_LAST;
						SIDE_XN: x = '0;
						default: x = XZ_LAST;
					endcase
					put_border(s, (s == SIDE_ZN || s == SIDE_ZP) ? x : z, y, rand_occ());
					query(x, y, z);
				end
			end
			ph++;
		end

		// lone voxel queried back to back
		gap_pct = 0;
		set_neighbors(4'h0);
		put_voxel(4'd8, 5'd16, 4'd8, 8'h5A);
		put_voxel(4'd8, 5'd16, 4'd7, 8'h00);
		put_voxel(4'd8, 5'd16, 4'd9, 8'h00);
		put_voxel(4'd7, 5'd16, 4'd8, 8'h00);
		put_voxel(4'd9, 5'd16, 4'd8, 8'h00);
		put_voxel(4'd8, 5'd17, 4'd8, 8'h00);
		put_voxel(4'd8, 5'd15, 4'd8, 8'h00);
		issue(KIND_RESTART, 4'd8, 5'd16, 4'd8, SIDE_ZN, 8'h00);
		repeat (LONE_QUERIES)
			issue(KIND_QUERY, 4'd8, 5'd16, 4'd8, 2'($urandom_range(0, 3)),
				BLOCK_W'($urandom_range(0, 255)));

		start <= 1'b0;
		do @(negedge clk); while (faces_due != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
design/vfc_pkg.sv
design/vfc_ram.sv
design/vfc_nbr_addr.sv
design/voxel_face_culling_core.sv
bench/face_cull_checker.sv
bench/tb_top.sv
